@@ sv/assert_macros.svh @@
// assert_macros.svh: concurrent assertion shorthands for the utf-8 decoder
// needs clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/u8d_pkg.sv @@
// u8d_pkg: item types, constants and push record for the utf-8 decoder
// used by u8d_core, u8d_queue and utf8_stream_decoder; depends on nothing
`default_nettype none

package u8d_pkg;

    // one raw text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_item_t;

    // one decoded result
    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic        last_of_run;
        logic        text_done;
    } cp_item_t;

    // results produced by one accepted byte, oldest first
    typedef struct packed {
        logic [1:0] count;
        cp_item_t   first;
        cp_item_t   second;
    } push_t;

    // code point constants
    localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
    localparam logic [30:0] SURR_LO      = 31'h0000D800;
    localparam logic [30:0] SURR_HI      = 31'h0000DFFF;
    localparam logic [30:0] NONCHAR_FFFE = 31'h0000FFFE;
    localparam logic [30:0] NONCHAR_FFFF = 31'h0000FFFF;
    localparam logic [30:0] CP_MAX       = 31'h0010FFFF;

    // byte classification constants
    localparam logic [7:0] LEAD_OVL_MASK = 8'hDE;
    localparam logic [7:0] LEAD_OVL_VAL  = 8'hC0;
    localparam logic [7:0] PAYLOAD_MASK  = 8'h3F;
    localparam logic [7:0] CONT_VAL      = 8'h80;
    localparam logic [7:0] CONT_MASK     = 8'hC0;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

@@ sv/u8d_core.sv @@
// u8d_core: sequence state and single-pass decode of one text byte
// depends on u8d_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module u8d_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire u8d_pkg::text_item_t item,
    input  wire logic                take,
    output u8d_pkg::push_t           push
);

    // sequence state
    logic [30:0] acc_reg,       acc_next;
    logic [2:0]  left_reg,      left_next;
    logic        ovl_seen_reg,  ovl_seen_next;
    logic        first_reg,     first_next;
    logic        ovl_lead_reg,  ovl_lead_next;
    logic [7:0]  ovl_mask_reg,  ovl_mask_next;

    logic [7:0]  b;
    logic        eot;
    logic        cont;
    logic        pending;
    logic        ovl_now;
    logic [30:0] acc_shift;
    logic [2:0]  left_dec;
    logic        value_bad;

    // lead byte decode
    logic        lead_imm;
    logic [20:0] lead_cp;
    logic        lead_mal;
    logic [2:0]  lead_n;
    logic [4:0]  lead_bits;
    logic [7:0]  lead_mask;
    logic        lead_ovl;
    logic        lead_olead;

    u8d_pkg::cp_item_t res_item;
    u8d_pkg::push_t    push_raw;

    assign b       = item.text_byte;
    assign eot     = item.end_of_text;
    assign cont    = (b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_VAL;
    assign pending = left_reg != 3'd0;

    // continuation byte path
    assign ovl_now   = ovl_seen_reg | (first_reg & ovl_lead_reg &
                       ((b & ovl_mask_reg) == u8d_pkg::CONT_VAL));
    assign acc_shift = {acc_reg[24:0], 6'(b & u8d_pkg::PAYLOAD_MASK)};
    assign left_dec  = left_reg - 3'd1;
    assign value_bad = ovl_now ||
                       (acc_shift >= u8d_pkg::SURR_LO && acc_shift <= u8d_pkg::SURR_HI) ||
                       acc_shift == u8d_pkg::NONCHAR_FFFE ||
                       acc_shift == u8d_pkg::NONCHAR_FFFF ||
                       acc_shift > u8d_pkg::CP_MAX;

    // lead byte classification
    always_comb
    begin
        lead_imm  = 1'b0;
        lead_cp   = u8d_pkg::REPLACEMENT;
        lead_mal  = 1'b1;
        lead_n    = 3'd1;
        lead_bits = b[4:0];
        lead_mask = 8'h00;
        lead_ovl  = 1'b0;
        case (b) inside
            [8'h00:8'h7F]:
            begin
                lead_imm = 1'b1;
                lead_cp  = 21'(b);
                lead_mal = 1'b0;
            end
            [8'h80:8'hBF], [8'hFE:8'hFF]:
            begin
                lead_imm = 1'b1;
            end
            [8'hFC:8'hFD]:
            begin
                lead_n    = 3'd5;
                lead_bits = {4'd0, b[0]};
                lead_mask = 8'hFC;
            end
            [8'hF8:8'hFB]:
            begin
                lead_n    = 3'd4;
                lead_bits = {3'd0, b[1:0]};
                lead_mask = 8'hF8;
            end
            [8'hF0:8'hF7]:
            begin
                lead_n    = 3'd3;
                lead_bits = {2'd0, b[2:0]};
                lead_mask = 8'hF0;
            end
            [8'hE0:8'hEF]:
            begin
                lead_n    = 3'd2;
                lead_bits = {1'b0, b[3:0]};
                lead_mask = 8'hE0;
            end
            default:
            begin
                lead_ovl = (b & u8d_pkg::LEAD_OVL_MASK) == u8d_pkg::LEAD_OVL_VAL;
            end
        endcase
    end

    assign lead_olead = (lead_mask != 8'h00) && (b == lead_mask);

    // next state and results for the byte on the port
    always_comb
    begin
        acc_next      = acc_reg;
        left_next     = left_reg;
        ovl_seen_next = ovl_seen_reg;
        first_next    = first_reg;
        ovl_lead_next = ovl_lead_reg;
        ovl_mask_next = ovl_mask_reg;
        push_raw      = '0;
        res_item      = '0;
        if (pending && cont)
        begin
            if (left_dec == 3'd0)
            begin
                push_raw.count = 2'd1;
                if (value_bad)
                    push_raw.first = {u8d_pkg::REPLACEMENT, 1'b1, 1'b1, eot};
                else
                    push_raw.first = {acc_shift[20:0], 1'b0, 1'b1, eot};
                acc_next      = '0;
                left_next     = '0;
                ovl_seen_next = 1'b0;
                first_next    = 1'b0;
                ovl_lead_next = 1'b0;
                ovl_mask_next = '0;
            end
            else if (eot)
            begin
                push_raw.count = 2'd1;
                push_raw.first = {u8d_pkg::REPLACEMENT, 1'b1, 1'b1, 1'b1};
                acc_next      = '0;
                left_next     = '0;
                ovl_seen_next = 1'b0;
                first_next    = 1'b0;
                ovl_lead_next = 1'b0;
                ovl_mask_next = '0;
            end
            else
            begin
                acc_next      = acc_shift;
                left_next     = left_dec;
                ovl_seen_next = ovl_now;
                first_next    = 1'b0;
            end
        end
        else
        begin
            // interrupted sequence closes first
            if (pending)
            begin
                push_raw.count = 2'd1;
                push_raw.first = {u8d_pkg::REPLACEMENT, 1'b1, 1'b0, 1'b0};
            end
            acc_next      = '0;
            left_next     = '0;
            ovl_seen_next = 1'b0;
            first_next    = 1'b0;
            ovl_lead_next = 1'b0;
            ovl_mask_next = '0;
            if (lead_imm || eot)
            begin
                if (lead_imm)
                    res_item = {lead_cp, lead_mal, 1'b1, eot};
                else
                    res_item = {u8d_pkg::REPLACEMENT, 1'b1, 1'b1, 1'b1};
                if (pending)
                begin
                    push_raw.count  = 2'd2;
                    push_raw.second = res_item;
                end
                else
                begin
                    push_raw.count = 2'd1;
                    push_raw.first = res_item;
                end
            end
            else
            begin
                acc_next      = 31'(lead_bits);
                left_next     = lead_n;
                ovl_seen_next = lead_ovl;
                first_next    = 1'b1;
                ovl_lead_next = lead_olead;
                ovl_mask_next = lead_olead ? lead_mask : 8'h00;
            end
        end
    end

    // results leave only with an accepted byte
    always_comb
    begin
        push = push_raw;
        if (!take)
            push.count = 2'd0;
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            left_reg     <= '0;
            ovl_seen_reg <= 1'b0;
            first_reg    <= 1'b0;
            ovl_lead_reg <= 1'b0;
            ovl_mask_reg <= '0;
        end
        else if (take)
        begin
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            ovl_seen_reg <= ovl_seen_next;
            first_reg    <= first_next;
            ovl_lead_reg <= ovl_lead_next;
            ovl_mask_reg <= ovl_mask_next;
        end
    end

    // checks
    `ASSERT_CLK(a_left_range, left_reg <= 3'd5, "bytes left beyond a six-byte form")
    `ASSERT_CLK(a_pair_is_interrupt, (push.count == 2'd2) |-> (push.first.malformed && !push.first.last_of_run), "second result without an interrupted sequence")
    `ASSERT_CLK(a_idle_clear, (left_reg == 3'd0) |-> (acc_reg == '0 && !ovl_seen_reg && !ovl_lead_reg), "idle decoder holds sequence state")
    `ASSERT_NEVER(a_eot_leaves_open, $past(take && item.end_of_text) && left_reg != 3'd0, "sequence left open after end of text")

endmodule

`default_nettype wire

@@ sv/u8d_queue.sv @@
// u8d_queue: small result queue that takes up to two items per cycle
// depends on u8d_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module u8d_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire u8d_pkg::push_t    push,
    output logic                   space,
    output logic                   cp_valid,
    input  wire logic              cp_ready,
    output u8d_pkg::cp_item_t      cp_item
);

    u8d_pkg::cp_item_t entry_reg [u8d_pkg::QUEUE_DEPTH];

    logic [u8d_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [u8d_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [u8d_pkg::QUEUE_AW-1:0] wr_ptr_plus;
    logic [u8d_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic                         pop;

    // room for a full pair of results
    assign space       = count_reg <= u8d_pkg::QUEUE_CW'(u8d_pkg::QUEUE_DEPTH - 2);
    assign cp_valid    = count_reg != '0;
    assign cp_item     = entry_reg[rd_ptr_reg];
    assign pop         = cp_valid && cp_ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + u8d_pkg::QUEUE_AW'(push.count);
    assign count_next  = count_reg + u8d_pkg::QUEUE_CW'(push.count)
                         - u8d_pkg::QUEUE_CW'(pop);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus] <= push.second;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // checks
    `ASSERT_CLK(a_count_max, count_reg <= u8d_pkg::QUEUE_CW'(u8d_pkg::QUEUE_DEPTH), "result queue over depth")
    `ASSERT_CLK(a_pop_only, (pop && push.count == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1), "pop without push lost track of fill level")
    `ASSERT_CLK(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == u8d_pkg::QUEUE_AW'(count_reg), "queue pointers disagree with fill level")

endmodule

`default_nettype wire

@@ sv/utf8_stream_decoder.sv @@
// utf8_stream_decoder: top level of the byte-serial utf-8 decoder
// depends on u8d_pkg, u8d_core and u8d_queue
//
// Usage: text bytes enter on the byte channel (byte_valid / byte_ready /
// byte_item), one item per byte with its end_of_text mark. Decoded code
// points leave on the cp channel (cp_valid / cp_ready / cp_item). A byte
// gives zero, one or two result items; a pair arises only when a sequence
// is broken by a non-continuation byte.
// A result enters the queue as its completing byte is accepted and is
// offered once older items have left. Throughput: one byte per clock
// while byte_ready is high; the decode is a single combinational pass
// from the byte port into the sequence registers and a four-entry queue.
// byte_ready is high while the queue has room for two results, so with a
// stalled receiver the block keeps accepting bytes until the queue holds
// three or four items, then waits. No result is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the queue and returns the
// decoder to the idle state with no sequence pending.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_ready,
    input  wire u8d_pkg::text_item_t byte_item,
    output logic                     cp_valid,
    input  wire logic                cp_ready,
    output u8d_pkg::cp_item_t        cp_item
);

    u8d_pkg::push_t push;
    logic           take;
    logic           space;

    // byte accepted when the queue can hold its results
    assign byte_ready = space;
    assign take       = byte_valid && space;

    // decode state and single-pass logic
    u8d_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (byte_item),
        .take  (take),
        .push  (push)
    );

    // result queue towards the receiver
    u8d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space    (space),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready),
        .cp_item  (cp_item)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for the byte-serial utf-8 decoder utf8_stream_decoder
// drives text bytes from a queue, predicts the code points itself and checks each result item
// depends on u8d_pkg and the decoder rtl
`timescale 1ns / 1ps

module testbench;

    // lead byte thresholds
    localparam logic [7:0] LEAD_2B  = 8'hC0;
    localparam logic [7:0] LEAD_3B  = 8'hE0;
    localparam logic [7:0] LEAD_4B  = 8'hF0;
    localparam logic [7:0] LEAD_5B  = 8'hF8;
    localparam logic [7:0] LEAD_6B  = 8'hFC;
    localparam logic [7:0] LEAD_BAD = 8'hFE;
    localparam int ITEMS_PER_PHASE  = 425;
    localparam int REPORT_LIMIT     = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_ready;
    u8d_pkg::text_item_t byte_item = '0;
    logic                cp_valid;
    logic                cp_ready = 1'b0;
    u8d_pkg::cp_item_t   cp_item;

    u8d_pkg::text_item_t byte_pending[$];
    u8d_pkg::cp_item_t   cp_expected[$];
    int         bytes_queued = 0;
    int         fail_count = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;

    // decoder state as the bench sees it
    logic [30:0] seq_acc = '0;
    logic [2:0]  seq_left = '0;
    logic        seq_ovl_seen = 1'b0;
    logic        seq_first = 1'b0;
    logic        seq_ovl_lead = 1'b0;
    logic [7:0]  seq_ovl_mask = '0;

    utf8_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_item    (cp_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_seq();
        seq_acc = '0;
        seq_left = '0;
        seq_ovl_seen = 1'b0;
        seq_first = 1'b0;
        seq_ovl_lead = 1'b0;
        seq_ovl_mask = '0;
    endfunction

    function automatic void expect_cp(logic [20:0] cp, logic mal, logic last, logic done);
        u8d_pkg::cp_item_t e;
        e.code_point = cp;
        e.malformed = mal;
        e.last_of_run = last;
        e.text_done = done;
        cp_expected.push_back(e);
    endfunction

    function automatic bit value_rejected(logic [30:0] v);
        return seq_ovl_seen ||
               (v >= u8d_pkg::SURR_LO && v <= u8d_pkg::SURR_HI) ||
               v == u8d_pkg::NONCHAR_FFFE || v == u8d_pkg::NONCHAR_FFFF ||
               v > u8d_pkg::CP_MAX;
    endfunction

    // work out the result items of one accepted byte and advance the state
    function automatic void decode_byte(u8d_pkg::text_item_t it);
        logic [7:0] b;
        logic       eot;
        logic [7:0] lead_mask;
        b = it.text_byte;
        eot = it.end_of_text;
        if (seq_left != 0)
        begin
            if ((b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_VAL)
            begin
                if (seq_first && seq_ovl_lead &&
                    ((b & seq_ovl_mask) == u8d_pkg::CONT_VAL))
                    seq_ovl_seen = 1'b1;
                seq_first = 1'b0;
                seq_acc = {seq_acc[24:0], b[5:0]};
                seq_left = seq_left - 3'd1;
                if (seq_left == 0)
                begin
                    if (value_rejected(seq_acc))
                        expect_cp(u8d_pkg::REPLACEMENT, 1'b1, 1'b1, eot);
                    else
                        expect_cp(seq_acc[20:0], 1'b0, 1'b1, eot);
                    clear_seq();
                end
                else if (eot)
                begin
                    expect_cp(u8d_pkg::REPLACEMENT, 1'b1, 1'b1, 1'b1);
                    clear_seq();
                end
                return;
            end
            // sequence broken by a non-continuation byte
            expect_cp(u8d_pkg::REPLACEMENT, 1'b1, 1'b0, 1'b0);
            clear_seq();
        end
        if (b < 8'h80)
            expect_cp({13'd0, b}, 1'b0, 1'b1, eot);
        else if (b < LEAD_2B || b >= LEAD_BAD)
            expect_cp(u8d_pkg::REPLACEMENT, 1'b1, 1'b1, eot);
        else
        begin
            lead_mask = '0;
            if (b >= LEAD_6B)
            begin
                seq_left = 3'd5;
                seq_acc = 31'(b & 8'h01);
                lead_mask = LEAD_6B;
            end
            else if (b >= LEAD_5B)
            begin
                seq_left = 3'd4;
                seq_acc = 31'(b & 8'h03);
                lead_mask = LEAD_5B;
            end
            else if (b >= LEAD_4B)
            begin
                seq_left = 3'd3;
                seq_acc = 31'(b & 8'h07);
                lead_mask = LEAD_4B;
            end
            else if (b >= LEAD_3B)
            begin
                seq_left = 3'd2;
                seq_acc = 31'(b & 8'h0F);
                lead_mask = LEAD_3B;
            end
            else
            begin
                seq_left = 3'd1;
                seq_acc = 31'(b & 8'h1F);
                seq_ovl_seen = ((b & u8d_pkg::LEAD_OVL_MASK) == u8d_pkg::LEAD_OVL_VAL);
            end
            if (lead_mask != 0 && b == lead_mask)
            begin
                seq_ovl_lead = 1'b1;
                seq_ovl_mask = lead_mask;
            end
            seq_first = 1'b1;
            if (eot)
            begin
                expect_cp(u8d_pkg::REPLACEMENT, 1'b1, 1'b1, 1'b1);
                clear_seq();
            end
        end
    endfunction

    function automatic void report_failure(string what, u8d_pkg::cp_item_t want,
                                           u8d_pkg::cp_item_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display({"%0t %s: expected cp=%h mal=%b last=%b done=%b, ",
                      "got cp=%h mal=%b last=%b done=%b"},
                     $realtime, what, want.code_point, want.malformed, want.last_of_run,
                     want.text_done, got.code_point, got.malformed, got.last_of_run,
                     got.text_done);
    endfunction

    // byte driver: holds an item until taken, then loads the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                decode_byte(byte_item);
            if (byte_valid && !byte_ready)
                byte_valid <= 1'b1;
            else if (byte_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                byte_valid <= 1'b1;
                byte_item <= byte_pending.pop_front();
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // result monitor: compares each taken item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cp_ready <= 1'b0;
        else
        begin
            if (cp_valid && cp_ready)
            begin
                if (cp_expected.size() == 0)
                    report_failure("unexpected result", '0, cp_item);
                else if (cp_item.code_point !== cp_expected[0].code_point ||
                         cp_item.malformed !== cp_expected[0].malformed ||
                         cp_item.last_of_run !== cp_expected[0].last_of_run ||
                         cp_item.text_done !== cp_expected[0].text_done)
                    report_failure("mismatch", cp_expected.pop_front(), cp_item);
                else
                    void'(cp_expected.pop_front());
            end
            cp_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic queue_byte(logic [7:0] b, bit eot);
        u8d_pkg::text_item_t it;
        it.text_byte = b;
        it.end_of_text = eot;
        byte_pending.push_back(it);
        bytes_queued++;
    endtask

    // encode a value in len bytes (overlong if len is above the minimum), keep only the first few
    task automatic queue_char(logic [31:0] cp, int len, int keep, bit eot);
        logic [7:0] b;
        for (int k = 0; k < keep; k++)
        begin
            if (len == 1)
                b = cp[7:0] & 8'h7F;
            else if (k == 0)
                b = (8'hFF << (8 - len)) | (8'(cp >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
            else
                b = u8d_pkg::CONT_VAL |
                    (8'(cp >> (6 * (len - 1 - k))) & u8d_pkg::PAYLOAD_MASK);
            queue_byte(b, (k == keep - 1 && eot) || $urandom_range(63) == 0);
        end
    endtask

    function automatic int min_len(logic [31:0] cp);
        if (cp < 32'h80) return 1;
        if (cp < 32'h800) return 2;
        if (cp < 32'h10000) return 3;
        if (cp < 32'h200000) return 4;
        if (cp < 32'h4000000) return 5;
        return 6;
    endfunction

    // one text: mostly well-formed characters, with overlongs, bad values, noise and cut sequences
    task automatic queue_text();
        int          nchars;
        int          pick;
        int          len;
        int          keep;
        bit          eot_at_end;
        logic [31:0] cp;
        nchars = $urandom_range(1, 16);
        eot_at_end = ($urandom_range(3) != 0);
        for (int i = 0; i < nchars; i++)
        begin
            pick = $urandom_range(99);
            keep = 0;
            if (pick < 30)
                cp = $urandom_range(0, 32'h7F);
            else if (pick < 45)
                cp = $urandom_range(32'h80, 32'h7FF);
            else if (pick < 60)
                cp = $urandom_range(32'h800, 32'hFFFF);
            else if (pick < 70)
                cp = $urandom_range(32'h10000, 32'h10FFFF);
            else if (pick < 75)
            begin
                case ($urandom_range(2))
                    0: cp = $urandom_range(32'h110000, 32'h1FFFFF);
                    1: cp = $urandom_range(32'h200000, 32'h3FFFFFF);
                    default: cp = $urandom_range(32'h4000000, 32'h7FFFFFFF);
                endcase
            end
            else if (pick < 86)
            begin
                if (pick < 82)
                    cp = $urandom_range(0, 32'hFFFF);
                else if ($urandom_range(1) == 0)
                    cp = $urandom_range(32'hD800, 32'hDFFF);
                else
                    cp = $urandom_range(32'hFFFE, 32'hFFFF);
            end
            else if (pick < 93)
            begin
                // raw noise byte
                queue_byte(8'($urandom), (i == nchars - 1 && eot_at_end) || $urandom_range(63) == 0);
                continue;
            end
            else
                cp = $urandom_range(32'h80, 32'h10FFFF);
            len = min_len(cp);
            // overlong forms
            if (pick >= 75 && pick < 82 && len < 6)
                len = len + $urandom_range(1, 6 - len);
            else if (pick >= 82 && pick < 86 && $urandom_range(3) == 0)
                len = len + 1;
            keep = (pick >= 93) ? $urandom_range(1, len - 1) : len;
            queue_char(cp, len, keep, i == nchars - 1 && eot_at_end);
        end
    endtask

    // sender holds off here until every predicted item has come back
    task automatic wait_drained();
        while (byte_pending.size() != 0 || byte_valid || cp_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        int target;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        target = bytes_queued + ITEMS_PER_PHASE;
        while (bytes_queued < target)
            queue_text();
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ascii extremes, valid pair, overlong leads, surrogate
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b1);
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hC0, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hE0, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hED, 1'b0);
        queue_byte(8'hA0, 1'b0);
        queue_byte(8'h80, 1'b0);
        // lone continuation and the two bytes that never lead
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // sequence broken by an ascii byte
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h41, 1'b0);
        // end of text inside a sequence, then on an opening lead
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);
        queue_byte(8'hC3, 1'b1);
        // legacy five-byte lead, overlong
        queue_byte(8'hF8, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);

        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(17, 17);

        // allow for any stray item after the last prediction
        repeat (8) @(posedge clk);
        if (cp_expected.size() != 0)
        begin
            fail_count += cp_expected.size();
            $display("%0d predicted items never arrived", cp_expected.size());
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
